// ----- hw/rtl/ecfir_pkg.sv -----
// Shared widths, register codes, control structs and saturation helper for the compensation filter.
package ecfir_pkg;

  localparam int MAX_TAPS_DEF = 64;

  localparam int VOLT_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int COEF_W  = 18;
  localparam int IDX_W   = 6;
  localparam int TAPS_W  = 7;
  localparam int SCALE_W = 32;
  // A scaled current is the 32-bit product floored by 8, which always fits in 24 bits.
  localparam int HIST_W  = SCALE_W - 8;
  localparam int PROD_W  = COEF_W + HIST_W;
  localparam int CFG_W   = 16;

  typedef enum logic {
    REG_TAP_COUNT    = 1'b0,
    REG_CURRENT_GAIN = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_t;

  // Chain movement: push shifts history toward older taps, rotate circulates
  // history and coefficients toward cell zero.
  typedef struct packed {
    logic push;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic take;
  } mac_ctrl_t;

  function automatic logic signed [VOLT_W-1:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) begin
      return 16'sh7fff;
    end else if (x < -64'sd32768) begin
      return 16'sh8000;
    end
    return x[VOLT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/ecfir_cell.sv -----
// One tap cell of the chain: holds a scaled current and a kernel coefficient.
module ecfir_cell
  import ecfir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic signed [HIST_W-1:0] hist_prev,
  input  logic signed [HIST_W-1:0] hist_succ,
  input  logic signed [COEF_W-1:0] coef_succ,
  input  logic                     coef_we,
  input  logic signed [COEF_W-1:0] coef_wdata,
  output logic signed [HIST_W-1:0] hist,
  output logic signed [COEF_W-1:0] coef
);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctrl.push) begin
      hist <= hist_prev;
    end else if (ctrl.rotate) begin
      hist <= hist_succ;
    end
  end

  // Coefficients have no reset; the user must write an entry before it is read (not enforced here).
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      coef <= coef_succ;
    end else if (coef_we) begin
      coef <= coef_wdata;
    end
  end

endmodule

// ----- hw/rtl/ecfir_mac.sv -----
// Multiply-accumulate unit fed by the head cell of the chain.
module ecfir_mac
  import ecfir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [HIST_W-1:0] hist,
  output logic signed [PROD_W+$clog2(MAX_TAPS)-1:0] acc
);

  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_take;

  always_ff @(posedge clk) begin
    prod <= coef * hist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_take <= 1'b0;
      acc       <= '0;
    end else begin
      prod_take <= ctrl.take;
      if (ctrl.clear) begin
        acc <= '0;
      end else if (prod_take) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule

// ----- hw/rtl/electrode_compensation_fir_top.sv -----
// Top level of the active electrode compensation filter.
//
// The block removes the electrode's own voltage drop from a recorded voltage.
// Each sample item carries a voltage and an injected current; the current is
// scaled by the signed Q8.8 gain (floored) and pushed into a row of tap cells,
// newest first. The electrode estimate is the sum over the active taps of
// coefficient times scaled current, floored by 16 bits and saturated to 16 bits,
// and the result is the voltage minus that estimate, saturated. A sample item
// gives a valid result only once eff_taps+2 samples have arrived; before that
// the item still enters the history and returns a zero correction together with
// the last estimate. Coefficient items write one tap and return result_valid 0.
// Every item, of either kind, returns exactly one result item.
//
// Sequence: a coefficient item goes from acceptance straight to the output
// state, which loads the output register; a sample item passes the push
// state first, and one that gives a valid result then a full MAC rotation,
// drain and finish. The input is ready again in the cycle after the load.
// The sample path is long because of the single multiply-accumulate unit at
// the head of the cell chain: the chain rotates one full turn per compensated
// sample, so every tap passes the unit once and the chain is back in place at
// the end. One item is worked on at a time; ready is high whenever the
// sequencer is idle, even while a result waits in the output register. The
// user must write configuration through cfg_we only while no item is in
// flight, which the block does not enforce; it applies from the next item on.
module electrode_compensation_fir_top
  import ecfir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic signed [VOLT_W-1:0] voltage_in,
  input  logic signed [VOLT_W-1:0] current_in,
  input  logic [IDX_W-1:0]         coef_index,
  input  logic signed [COEF_W-1:0] coef_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VOLT_W-1:0] corrected_voltage,
  output logic signed [VOLT_W-1:0] electrode_estimate,
  output logic                     result_valid
);

  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int SW0   = $clog2(MAX_TAPS + 3);
  // Wide enough for the sample count, the tap count register and both plus two.
  localparam int NW    = ((SW0 > TAPS_W) ? SW0 : TAPS_W) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PUSH  = 6'b000010,
    S_MAC   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [TAPS_W-1:0]        tap_count;
  logic signed [GAIN_W-1:0] current_gain;

  // Item context held while the sequencer works.
  logic signed [SCALE_W-1:0] scaled_prod;
  logic signed [VOLT_W-1:0]  voltage_hold;
  logic                      item_valid;
  logic [NW-1:0]             samples_seen;
  logic signed [VOLT_W-1:0]  last_estimate;
  logic [CW-1:0]             step;

  logic          in_fire;
  logic          out_load;
  logic [NW-1:0] eff_taps;
  logic [NW-1:0] seen_inc;

  cell_ctrl_t               cell_ctrl;
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-17:0] est_wide;
  logic signed [VOLT_W:0]   vdiff;

  logic signed [HIST_W-1:0] hist [MAX_TAPS];
  logic signed [COEF_W-1:0] coef [MAX_TAPS];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= TAPS_W'(1);
      current_gain <= 16'sd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_COUNT:    tap_count    <= cfg_data[TAPS_W-1:0];
        REG_CURRENT_GAIN: current_gain <= cfg_data[GAIN_W-1:0];
        default:          ;
      endcase
    end
  end

  // A tap count of zero acts as one, and counts past the chain length clamp to it.
  always_comb begin
    if (tap_count == '0) begin
      eff_taps = NW'(1);
    end else if (NW'(tap_count) > NW'(MAX_TAPS)) begin
      eff_taps = NW'(MAX_TAPS);
    end else begin
      eff_taps = NW'(tap_count);
    end
  end

  assign seen_inc = (samples_seen < NW'(MAX_TAPS + 2)) ? samples_seen + NW'(1) : samples_seen;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (op == OP_SAMPLE) ? S_PUSH : S_OUT;
        end
      end
      S_PUSH:  state_next = item_valid ? S_MAC : S_OUT;
      S_MAC: begin
        if (step == CW'(MAX_TAPS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-item context. The validity of a sample is judged with the sample counted.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      samples_seen <= '0;
      step         <= '0;
    end else begin
      if (in_fire) begin
        if (op == OP_SAMPLE) begin
          samples_seen <= seen_inc;
          item_valid   <= (seen_inc >= eff_taps + NW'(2));
        end else begin
          item_valid <= 1'b0;
        end
      end
      if (state == S_PUSH) begin
        step <= '0;
      end else if (state == S_MAC) begin
        step <= step + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scaled_prod  <= current_in * current_gain;
      voltage_hold <= voltage_in;
    end
  end

  // Chain control: one push per sample, then, for a compensated sample, one full rotation past the MAC.
  always_comb begin
    cell_ctrl.push   = (state == S_PUSH);
    cell_ctrl.rotate = (state == S_MAC);
    mac_ctrl.clear   = in_fire;
    mac_ctrl.take    = (state == S_MAC) && (NW'(step) < eff_taps);
  end

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic signed [HIST_W-1:0] hist_prev;
    logic                     coef_we;

    if (i == 0) begin : g_head
      assign hist_prev = scaled_prod[SCALE_W-1:8];
    end else begin : g_body
      assign hist_prev = hist[i-1];
    end

    assign coef_we = in_fire && (op == OP_COEF) && (int'(coef_index) == i);

    ecfir_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .hist_prev  (hist_prev),
      .hist_succ  (hist[(i + 1) % MAX_TAPS]),
      .coef_succ  (coef[(i + 1) % MAX_TAPS]),
      .coef_we    (coef_we),
      .coef_wdata (coef_value),
      .hist       (hist[i]),
      .coef       (coef[i])
    );
  end

  ecfir_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .coef (coef[0]),
    .hist (hist[0]),
    .acc  (acc)
  );

  // Floor by 16 is an arithmetic shift; the estimate then saturates to 16 bits.
  assign est_wide = acc[ACC_W-1:16];
  assign vdiff    = (VOLT_W + 1)'(voltage_hold) - (VOLT_W + 1)'(last_estimate);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_estimate <= '0;
    end else if (state == S_FIN) begin
      last_estimate <= sat16(64'(est_wide));
    end
  end

  // Output register: holds a finished result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      corrected_voltage  <= item_valid ? sat16(64'(vdiff)) : '0;
      electrode_estimate <= last_estimate;
      result_valid       <= item_valid;
    end
  end

endmodule

// ----- hw/rtl/ecfir_checker.sv -----
// Port-level checker for the compensation filter, bound to the top level.
module ecfir_checker
  import ecfir_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     op,
  input logic signed [VOLT_W-1:0] voltage_in,
  input logic signed [VOLT_W-1:0] current_in,
  input logic [IDX_W-1:0]         coef_index,
  input logic signed [COEF_W-1:0] coef_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [VOLT_W-1:0] corrected_voltage,
  input logic signed [VOLT_W-1:0] electrode_estimate,
  input logic                     result_valid
);

  // Reset leaves no result item pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item pending after reset");

  // A result without compensation carries a zero correction.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_valid |-> corrected_voltage == '0)
    else $error("uncompensated result item with nonzero correction");

  // Once a sample item is accepted, the block leaves idle and drops ready.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_SAMPLE |=> !in_ready)
    else $error("sample item accepted back to back");

  // A waiting input item keeps valid high and its payload unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(op) && $stable(voltage_in)
      && $stable(current_in) && $stable(coef_index) && $stable(coef_value))
    else $error("waiting input item changed");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(corrected_voltage)
      && $stable(electrode_estimate) && $stable(result_valid))
    else $error("stalled result item changed");

endmodule

bind electrode_compensation_fir_top ecfir_checker u_ecfir_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the electrode compensation FIR filter.
`timescale 1ns / 1ps

module testbench;
  import ecfir_pkg::*;

  localparam int MAX_DEPTH = MAX_TAPS_DEF;
  // No item may stay still this long. The worst correct case is a long sender
  // pause, a full convolution and a run of receiver stalls, far below it.
  localparam int STALL_LIMIT = 4000;
  // Outlasts the processing of a compensated sample, so this covers any stray result.
  localparam int SETTLE_CYCLES = MAX_DEPTH + 16;

  // One input item, with every field present whatever the operation.
  typedef struct packed {
    op_t               op;
    logic signed [15:0] volt;
    logic signed [15:0] curr;
    logic [5:0]         idx;
    logic signed [17:0] coef;
  } fir_item_t;

  // One result item as the filter should report it.
  typedef struct packed {
    logic signed [15:0] corr;
    logic signed [15:0] est;
    logic               vld;
  } comp_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     op = 1'b0;
  logic signed [VOLT_W-1:0] voltage_in = '0;
  logic signed [VOLT_W-1:0] current_in = '0;
  logic [IDX_W-1:0]         coef_index = '0;
  logic signed [COEF_W-1:0] coef_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [VOLT_W-1:0] corrected_voltage;
  logic signed [VOLT_W-1:0] electrode_estimate;
  logic                     result_valid;

  electrode_compensation_fir_top dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .op                 (op),
    .voltage_in         (voltage_in),
    .current_in         (current_in),
    .coef_index         (coef_index),
    .coef_value         (coef_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .corrected_voltage  (corrected_voltage),
    .electrode_estimate (electrode_estimate),
    .result_valid       (result_valid)
  );

  // Shadow of the filter: register settings, scaled-current history (newest at
  // index 0), tap store with a record of which taps hold a value, the sample
  // count and the estimate held between compensated samples.
  logic [6:0]         tap_setting = 7'd1;
  logic [15:0]        gain_setting = 16'd256;
  int                 scaled_hist [MAX_DEPTH];
  logic signed [17:0] kernel_taps [MAX_DEPTH];
  bit                 kernel_written [MAX_DEPTH];
  int                 sample_count = 0;
  logic signed [15:0] held_estimate = '0;

  comp_result_t pending_corrections[$];

  int  err_count = 0;
  int  n_samples = 0;
  int  n_coefs = 0;
  int  n_compensated = 0;
  int  n_cfg_writes = 0;
  int  quiet_cycles = 0;
  // While set, neither side inserts idle cycles.
  bit  quiet_run = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Tap settings outside 1..MAX_TAPS are pulled back to the nearest end.
  function automatic int active_taps(input logic [6:0] t);
    if (t == 0) return 1;
    if (t > MAX_DEPTH) return MAX_DEPTH;
    return t;
  endfunction

  function automatic logic [15:0] clamp16(input longint x);
    if (x > 32767) return 16'h7fff;
    if (x < -32768) return 16'h8000;
    return 16'(x);
  endfunction

  // Works out the result of one accepted item and advances the shadow state.
  // The current is scaled by the Q8.8 gain and floored; the convolution sum is
  // exact and floored by 16 bits before saturation.
  function automatic comp_result_t compensate(input fir_item_t it);
    comp_result_t r;
    longint       acc;
    longint       scaled;
    int           n;
    r.corr = '0;
    r.vld  = 1'b0;
    if (it.op == OP_COEF) begin
      kernel_taps[it.idx] = it.coef;
      kernel_written[it.idx] = 1'b1;
    end else begin
      n = active_taps(tap_setting);
      for (int i = MAX_DEPTH - 1; i > 0; i--) scaled_hist[i] = scaled_hist[i-1];
      scaled = longint'($signed(it.curr)) * longint'($signed(gain_setting));
      scaled_hist[0] = int'(scaled >>> 8);
      if (sample_count < MAX_DEPTH + 2) sample_count++;
      // The history always moves, but the estimate is formed only once the
      // active taps plus two samples have been seen.
      if (sample_count >= n + 2) begin
        acc = 0;
        for (int i = 0; i < n; i++) begin
          acc += longint'($signed(kernel_taps[i])) * longint'(scaled_hist[i]);
        end
        held_estimate = clamp16(acc >>> 16);
        r.corr = clamp16(longint'($signed(it.volt)) - longint'($signed(held_estimate)));
        r.vld  = 1'b1;
      end
    end
    r.est = held_estimate;
    return r;
  endfunction

  // Field values lean on the ends of the range and on small magnitudes, so
  // that estimates and corrections do not all sit at the saturation rails.
  function automatic logic [15:0] pick16();
    int s;
    s = $urandom_range(600);
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5, 6, 7: return 16'(s - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [17:0] pick18();
    int s;
    s = $urandom_range(6000);
    case ($urandom_range(15))
      0: return 18'h20000;
      1: return 18'h1ffff;
      2: return 18'h00000;
      3: return 18'h3ffff;
      4, 5, 6, 7, 8: return 18'(s - 3000);
      default: return 18'($urandom);
    endcase
  endfunction

  // Unused fields of an item carry random noise, which the filter must ignore.
  function automatic fir_item_t random_item();
    fir_item_t it;
    it.op   = ($urandom_range(99) < 15) ? OP_COEF : OP_SAMPLE;
    it.volt = pick16();
    it.curr = pick16();
    it.idx  = 6'($urandom_range(63));
    it.coef = pick18();
    return it;
  endfunction

  function automatic fir_item_t coef_item(input logic [5:0] i, input logic [17:0] v);
    fir_item_t it;
    it = random_item();
    it.op = OP_COEF;
    it.idx = i;
    it.coef = v;
    return it;
  endfunction

  function automatic fir_item_t sample_item(input logic [15:0] v, input logic [15:0] c);
    fir_item_t it;
    it = random_item();
    it.op = OP_SAMPLE;
    it.volt = v;
    it.curr = c;
    return it;
  endfunction

  // Called at a clock edge. Sometimes drops valid for a while first; most
  // pauses are short, a few outlast a whole convolution.
  task automatic send_item(input fir_item_t it);
    if (!quiet_run && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(20, 90)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= it.op;
    voltage_in <= it.volt;
    current_in <= it.curr;
    coef_index <= it.idx;
    coef_value <= it.coef;
    do @(posedge clk); while (!in_ready);
    if (it.op == OP_COEF) n_coefs++;
    else n_samples++;
    pending_corrections.insert(pending_corrections.size(), compensate(it));
  endtask

  // Every item returns one result, so the filter is idle once none is pending.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == REG_TAP_COUNT) tap_setting = d[6:0];
    else gain_setting = d;
    n_cfg_writes++;
    @(posedge clk);
  endtask

  // A tap is never read before it has been written: any missing tap below the
  // new active count gets a random coefficient before the setting changes.
  // The unused upper data bits carry noise.
  task automatic set_tap_count(input logic [6:0] t);
    for (int i = 0; i < active_taps(t); i++) begin
      if (!kernel_written[i]) send_item(coef_item(6'(i), pick18()));
    end
    wait_idle();
    write_reg(REG_TAP_COUNT, {9'($urandom), t});
  endtask

  task automatic set_gain(input logic [15:0] g);
    wait_idle();
    write_reg(REG_CURRENT_GAIN, g);
  endtask

  // Warm-up at reset settings: the first samples are not compensated, the
  // third is. Then the tap count grows mid-stream with the history kept, and
  // validity is judged again against the larger count.
  task automatic test_warm_up();
    send_item(coef_item(6'd0, 18'sd65536));
    send_item(sample_item(16'sd100, 16'sd50));
    send_item(sample_item(-16'sd1200, 16'sd7));
    send_item(sample_item(16'sd3000, -16'sd40));
    set_tap_count(7'd4);
    repeat (3) send_item(sample_item(pick16(), pick16()));
  endtask

  // A tap count of zero acts as one; a zero gain wipes out the current.
  task automatic test_tap_limits();
    set_tap_count(7'd0);
    send_item(sample_item(16'sd2500, 16'sd1000));
    set_gain(16'h0000);
    send_item(sample_item(-16'sd2500, 16'h7fff));
  endtask

  // Extremes of gain, current, voltage and coefficient, driving the estimate
  // and the correction into saturation in both directions.
  task automatic test_extremes();
    set_gain(16'h8000);
    send_item(coef_item(6'd0, 18'h1ffff));
    send_item(sample_item(16'h8000, 16'h8000));
    send_item(sample_item(16'h7fff, 16'h7fff));
    send_item(coef_item(6'd0, 18'h20000));
    send_item(coef_item(6'd63, 18'h1ffff));
    set_gain(16'h7fff);
    send_item(sample_item(16'h7fff, 16'h8000));
    send_item(sample_item(16'h8000, 16'h7fff));
    send_item(sample_item(16'h0000, 16'h0000));
  endtask

  // Random phases, each at its own tap count and gain. The first runs with no
  // idling on either side; later ones visit the full depth and the settings
  // above it, which require the whole tap store to be loaded.
  task automatic test_random();
    logic [6:0]  t;
    logic [15:0] g;
    for (int ph = 0; ph < 12; ph++) begin
      quiet_run = (ph == 0);
      case (ph)
        0: t = 7'($urandom_range(1, 8));
        1: t = 7'd64;
        2: t = 7'd127;
        3: t = 7'd0;
        4: t = 7'd1;
        5: t = 7'd65;
        default: t = ($urandom_range(1) == 0) ? 7'($urandom_range(1, 8)) : 7'($urandom);
      endcase
      case (ph % 6)
        0: g = 16'd256;
        1: g = 16'h8000;
        2: g = 16'h7fff;
        3: g = 16'h0000;
        4: g = 16'($urandom_range(0, 1024) - 512);
        default: g = 16'($urandom);
      endcase
      set_tap_count(t);
      set_gain(g);
      repeat (148) send_item(random_item());
    end
    quiet_run = 1'b0;
  endtask

  // Receiver side: stalls about a quarter of the cycles except in quiet runs.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_run || ($urandom_range(99) >= 24);
    end
  end

  // Each result is matched against the oldest pending prediction.
  always @(posedge clk) begin : check_results
    comp_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_corrections.size() == 0) begin
        $display("%0t: unexpected result: corrected %0d, estimate %0d, valid %0b",
                 $time, corrected_voltage, electrode_estimate, result_valid);
        err_count++;
      end else begin
        want = pending_corrections[0];
        pending_corrections.delete(0);
        if (want.vld) n_compensated++;
        if (corrected_voltage !== want.corr) begin
          $display("%0t: corrected_voltage expected %0d, actual %0d",
                   $time, $signed(want.corr), corrected_voltage);
          err_count++;
        end
        if (electrode_estimate !== want.est) begin
          $display("%0t: electrode_estimate expected %0d, actual %0d",
                   $time, $signed(want.est), electrode_estimate);
          err_count++;
        end
        if (result_valid !== want.vld) begin
          $display("%0t: result_valid expected %0b, actual %0b",
                   $time, want.vld, result_valid);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("[electrode_compensation_fir_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      scaled_hist[i] = 0;
      kernel_taps[i] = '0;
      kernel_written[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_warm_up();
    test_tap_limits();
    test_extremes();
    test_random();

    // Drain, then give any stray result time to show up.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_corrections.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_corrections.size());
      err_count++;
    end

    $display("Run covered %0d sample items (%0d compensated) and %0d coefficient items,",
             n_samples, n_compensated, n_coefs);
    $display("with %0d register writes spanning tap counts 0 to 127 and gains at both ends.",
             n_cfg_writes);
    if (err_count == 0) begin
      $display("[electrode_compensation_fir_top] OK");
    end else begin
      $display("[electrode_compensation_fir_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ecfir_pkg.sv
hw/rtl/ecfir_cell.sv
hw/rtl/ecfir_mac.sv
hw/rtl/electrode_compensation_fir_top.sv
hw/rtl/ecfir_checker.sv
tb/testbench.sv
